FILE: hw/rtl/mdfd_pkg.sv
// Shared types, sizes and codes for the masked delta frame decoder.
package mdfd_pkg;

  // Frame geometry
  localparam int ANGLE_ROWS  = 128;
  localparam int RING_COUNT  = 16;
  localparam int STORE_DEPTH = ANGLE_ROWS * RING_COUNT;

  localparam int ROW_W  = (ANGLE_ROWS > 1) ? $clog2(ANGLE_ROWS) : 1;
  localparam int RING_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Field widths of the channels
  localparam int COLOUR_W    = 24;
  localparam int MODE_W      = 2;
  localparam int ANGLE_IDX_W = 7;
  localparam int RING_IDX_W  = 4;

  typedef logic [COLOUR_W-1:0]    colour_t;
  typedef logic [MODE_W-1:0]      mode_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [RING_W-1:0]      ring_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [ANGLE_IDX_W-1:0] angle_idx_t;
  typedef logic [RING_IDX_W-1:0]  ring_idx_t;

  // Pixel source codes
  localparam mode_t MODE_NEW   = 2'b00;
  localparam mode_t MODE_KEEP  = 2'b01;
  localparam mode_t MODE_LEFT  = 2'b10;
  localparam mode_t MODE_ABOVE = 2'b11;

  // Command codes
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_RAW    = 1'b1;

  // Current scan position, from the position counters
  typedef struct packed {
    row_t  row;
    ring_t ring;
    addr_t addr;
    addr_t above_addr;
    logic  row_first;
    logic  ring_first;
    logic  frame_last;
  } pos_t;

  // One item at the select stage, beside its store read data
  typedef struct packed {
    logic    cmd;
    mode_t   mode;
    colour_t colour;
    logic    row_first;
    logic    ring_first;
    logic    use_fwd;
  } sel_req_t;

endpackage

FILE: hw/rtl/mdfd_in_if.sv
// Input channel of the frame decoder: command, mode and colour.
interface mdfd_in_if;
  import mdfd_pkg::*;

  logic    valid;
  logic    ready;
  logic    cmd;
  mode_t   mode;
  colour_t colour;

  modport source (output valid, cmd, mode, colour, input ready);
  modport sink   (input valid, cmd, mode, colour, output ready);
endinterface

FILE: hw/rtl/mdfd_out_if.sv
// Result channel of the frame decoder: decoded pixel and its position.
interface mdfd_out_if;
  import mdfd_pkg::*;

  logic       valid;
  logic       ready;
  colour_t    pixel_colour;
  angle_idx_t angle_index;
  ring_idx_t  ring_index;
  logic       took_colour;
  logic       frame_last;

  modport source (output valid, pixel_colour, angle_index, ring_index, took_colour,
                  frame_last, input ready);
  modport sink   (input valid, pixel_colour, angle_index, ring_index, took_colour,
                  frame_last, output ready);
endinterface

FILE: hw/rtl/mdfd_ram.sv
// Generic RAM: one write port, two read ports with enabled, registered read data.
module mdfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [WIDTH-1:0]                     wd,
  input  logic                                 re0,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra0,
  output logic [WIDTH-1:0]                     rd0,
  input  logic                                 re1,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra1,
  output logic [WIDTH-1:0]                     rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read ports: data holds while the enable is low
  always_ff @(posedge clk) begin
    if (re0) begin
      rd0 <= mem[ra0];
    end
    if (re1) begin
      rd1 <= mem[ra1];
    end
  end

endmodule

FILE: hw/rtl/mdfd_pos.sv
// Scan position counters: row, ring and linear store address, row-major.
module mdfd_pos (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  output mdfd_pkg::pos_t pos
);
  import mdfd_pkg::*;

  row_t  row_r,  row_nxt;
  ring_t ring_r, ring_nxt;
  addr_t addr_r, addr_nxt;
  logic  ring_end, row_end;

  assign ring_end = (ring_r == RING_W'(RING_COUNT - 1));
  assign row_end  = (row_r == ROW_W'(ANGLE_ROWS - 1));

  // Advance one pixel per transfer, wrap at the frame end
  always_comb begin
    row_nxt  = row_r;
    ring_nxt = ring_r;
    addr_nxt = addr_r;
    if (step) begin
      if (ring_end) begin
        ring_nxt = '0;
        row_nxt  = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        ring_nxt = ring_r + RING_W'(1);
      end
      addr_nxt = (ring_end && row_end) ? '0 : addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      ring_r <= '0;
      addr_r <= '0;
    end else begin
      row_r  <= row_nxt;
      ring_r <= ring_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign pos.row        = row_r;
  assign pos.ring       = ring_r;
  assign pos.addr       = addr_r;
  assign pos.above_addr = addr_r - ADDR_W'(RING_COUNT);
  assign pos.row_first  = (row_r == '0);
  assign pos.ring_first = (ring_r == '0);
  assign pos.frame_last = ring_end && row_end;

endmodule

FILE: hw/rtl/mdfd_sel.sv
// Pixel source select: new colour, old value, left neighbour or pixel above.
module mdfd_sel (
  input  mdfd_pkg::sel_req_t req,
  input  mdfd_pkg::colour_t  old_colour,
  input  mdfd_pkg::colour_t  above_colour,
  input  mdfd_pkg::colour_t  last_colour,
  output mdfd_pkg::colour_t  pix,
  output logic               took
);
  import mdfd_pkg::*;

  colour_t above_val;

  // Pixel written just before this one may be the one above (single ring)
  assign above_val = req.use_fwd ? last_colour : above_colour;

  always_comb begin
    pix  = old_colour;
    took = 1'b0;
    if (req.cmd == CMD_RAW) begin
      pix  = req.colour;
      took = 1'b1;
    end else begin
      unique case (req.mode)
        MODE_NEW: begin
          pix  = req.colour;
          took = 1'b1;
        end
        MODE_KEEP:  pix = old_colour;
        MODE_LEFT:  pix = req.ring_first ? old_colour : last_colour;
        MODE_ABOVE: pix = req.row_first ? old_colour : above_val;
        default:    pix = old_colour;
      endcase
    end
  end

endmodule

FILE: hw/rtl/masked_delta_frame_decoder.sv
// Top level of the masked delta frame decoder: store pipeline and result register.
//
//   channel | port   | direction | transfer carries
//   --------+--------+-----------+-------------------------------------------
//   input   | in_ch  | sink      | cmd, mode, colour
//   result  | out_ch | source    | pixel_colour, angle_index, ring_index,
//           |        |           | took_colour, frame_last
//
// One pixel per cycle sustained while the result channel is ready. A result
// reaches the output register through the select stage: the frame store reads
// (own entry and the entry one row up) are registered with the input at the
// transfer, and the select and the store write happen as that stage moves on.
// No clearing pass after reset: until the first frame has been written once, the
// pixel's own entry reads as black. A stalled result holds the select stage,
// and input is taken again as soon as the output register drains.
module masked_delta_frame_decoder (
  input logic        clk,
  input logic        rst_n,
  mdfd_in_if.sink    in_ch,
  mdfd_out_if.source out_ch
);
  import mdfd_pkg::*;

  pos_t     pos;
  logic     in_xfer;
  logic     s1_adv;
  logic     fwd_hit;
  colour_t  rd_old, rd_above;
  colour_t  old_colour;
  colour_t  pix;
  logic     took;
  sel_req_t sel_req;

  // Select stage registers
  logic     s1_valid_r, s1_valid_nxt;
  logic     s1_cmd_r;
  mode_t    s1_mode_r;
  colour_t  s1_colour_r;
  row_t     s1_row_r;
  ring_t    s1_ring_r;
  addr_t    s1_addr_r;
  logic     s1_row_first_r;
  logic     s1_ring_first_r;
  logic     s1_last_r;
  logic     s1_fwd_r;

  // Decoder state
  colour_t  last_pixel_r;
  logic     primed_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  colour_t    out_pix_r;
  angle_idx_t out_angle_r;
  ring_idx_t  out_ring_r;
  logic       out_took_r;
  logic       out_last_r;

  // Handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Position counters
  mdfd_pos u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_xfer),
    .pos   (pos)
  );

  // Frame store: reads at transfer, write as the select stage moves on
  mdfd_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk (clk),
    .we  (s1_adv),
    .wa  (s1_addr_r),
    .wd  (pix),
    .re0 (in_xfer),
    .ra0 (pos.addr),
    .rd0 (rd_old),
    .re1 (in_xfer),
    .ra1 (pos.above_addr),
    .rd1 (rd_above)
  );

  // Entry above is being written in this very cycle
  assign fwd_hit = s1_adv && (pos.above_addr == s1_addr_r);

  // Select stage
  assign s1_valid_nxt = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r        <= in_ch.cmd;
      s1_mode_r       <= in_ch.mode;
      s1_colour_r     <= in_ch.colour;
      s1_row_r        <= pos.row;
      s1_ring_r       <= pos.ring;
      s1_addr_r       <= pos.addr;
      s1_row_first_r  <= pos.row_first;
      s1_ring_first_r <= pos.ring_first;
      s1_last_r       <= pos.frame_last;
      s1_fwd_r        <= fwd_hit;
    end
  end

  // Own entry is black until the first full frame has been written
  assign old_colour = primed_r ? rd_old : '0;

  assign sel_req.cmd        = s1_cmd_r;
  assign sel_req.mode       = s1_mode_r;
  assign sel_req.colour     = s1_colour_r;
  assign sel_req.row_first  = s1_row_first_r;
  assign sel_req.ring_first = s1_ring_first_r;
  assign sel_req.use_fwd    = s1_fwd_r;

  mdfd_sel u_sel (
    .req          (sel_req),
    .old_colour   (old_colour),
    .above_colour (rd_above),
    .last_colour  (last_pixel_r),
    .pix          (pix),
    .took         (took)
  );

  // Last written colour and first-frame flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pixel_r <= '0;
      primed_r     <= 1'b0;
    end else if (s1_adv) begin
      last_pixel_r <= pix;
      if (s1_last_r) begin
        primed_r <= 1'b1;
      end
    end
  end

  // Output register
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r   <= pix;
      out_angle_r <= ANGLE_IDX_W'(s1_row_r);
      out_ring_r  <= RING_IDX_W'(s1_ring_r);
      out_took_r  <= took;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_colour = out_pix_r;
  assign out_ch.angle_index  = out_angle_r;
  assign out_ch.ring_index   = out_ring_r;
  assign out_ch.took_colour  = out_took_r;
  assign out_ch.frame_last   = out_last_r;

endmodule
